// ===== hw/rtl/vhps_pkg.sv =====
// Package for the vertical half-pixel shift block.
// Holds result types, field widths, register indexes and default sizes.
// No dependencies.
`timescale 1ns / 1ps

package vhps_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  localparam int PIX_W  = 8;
  localparam int ROW_W  = 10;
  localparam int COL_W  = 10;
  localparam int CFG_W  = 11;
  localparam int CIDX_W = 2;

  localparam int MAX_RES    = 3;
  localparam int FIFO_DEPTH = 8;

  localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CIDX_W-1:0] REG_SHIFT_UP     = 2'd2;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 11'd720;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 11'd576;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             run_last;
    logic             frame_end;
  } res_t;

  typedef struct packed {
    logic [1:0]         cnt;
    res_t [MAX_RES-1:0] item;
  } res_bundle_t;

endpackage

// ===== hw/rtl/vhps_line_buf.sv =====
// Line memory holding the three previous source rows per column.
// One synchronous read and one write per cycle, with write-to-read forwarding.
// Depends on vhps_pkg.
`timescale 1ns / 1ps

module vhps_line_buf #(
  parameter int DEPTH = vhps_pkg::MAX_WIDTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [AW-1:0]               rd_addr,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [3*vhps_pkg::PIX_W-1:0] wr_data,
  output logic [3*vhps_pkg::PIX_W-1:0] rd_data
);

  logic [3*vhps_pkg::PIX_W-1:0] mem [DEPTH];
  logic [3*vhps_pkg::PIX_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data_r <= wr_data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/vhps_kernel.sv =====
// Filter kernel: builds the zero to three results of one source pixel.
// Four-tap inner filter, two-tap edge average, clamp, row and column tags.
// Depends on vhps_pkg.
`timescale 1ns / 1ps

module vhps_kernel #(
  parameter int RW = 10,
  parameter int CW = 10
) (
  input  logic [vhps_pkg::PIX_W-1:0] cur,
  input  logic [vhps_pkg::PIX_W-1:0] m1,
  input  logic [vhps_pkg::PIX_W-1:0] m2,
  input  logic [vhps_pkg::PIX_W-1:0] m3,
  input  logic [RW-1:0]              row,
  input  logic [CW-1:0]              col,
  input  logic [RW-1:0]              hm1,
  input  logic                       up,
  input  logic                       last_row,
  input  logic                       last_col,
  output vhps_pkg::res_bundle_t      res
);

  logic [8:0]                 avg_sum;
  logic [vhps_pkg::PIX_W-1:0] avg_pix;
  logic [11:0]                tap_v;
  logic [8:0]                 tap_q;
  logic [vhps_pkg::PIX_W-1:0] tap_pix;
  logic [vhps_pkg::COL_W-1:0] col_o;
  logic [1:0]                 k;

  assign avg_sum = {1'b0, m1} + {1'b0, cur};
  assign avg_pix = avg_sum[8:1];
  assign tap_v   = 12'd5 * ({4'd0, m2} + {4'd0, m1}) + 12'd512
                   - ({4'd0, m3} + {4'd0, cur});
  assign tap_q   = tap_v[11:3];
  assign col_o   = vhps_pkg::COL_W'(col);

  always_comb begin
    if (tap_q < 9'd64) begin
      tap_pix = '0;
    end else if (tap_q > 9'd319) begin
      tap_pix = 8'd255;
    end else begin
      tap_pix = 8'(tap_q - 9'd64);
    end
  end

  always_comb begin
    res = '0;
    k   = '0;
    if ((row == '0) && up) begin
      res.item[k] = '{pixel: cur, row: '0, col: col_o, run_last: 1'b0, frame_end: 1'b0};
      k = k + 2'd1;
    end
    if (row == RW'(1)) begin
      res.item[k] = '{pixel: avg_pix, row: vhps_pkg::ROW_W'(up), col: col_o,
                      run_last: 1'b0, frame_end: 1'b0};
      k = k + 2'd1;
    end
    if (row >= RW'(3)) begin
      res.item[k] = '{pixel: tap_pix,
                      row: vhps_pkg::ROW_W'(up ? row - RW'(1) : row - RW'(2)),
                      col: col_o, run_last: 1'b0, frame_end: 1'b0};
      k = k + 2'd1;
    end
    if (last_row) begin
      res.item[k] = '{pixel: avg_pix,
                      row: vhps_pkg::ROW_W'(up ? hm1 : hm1 - RW'(1)),
                      col: col_o, run_last: 1'b0, frame_end: 1'b0};
      k = k + 2'd1;
      if (!up) begin
        res.item[k] = '{pixel: cur, row: vhps_pkg::ROW_W'(hm1), col: col_o,
                        run_last: 1'b0, frame_end: 1'b0};
        k = k + 2'd1;
      end
    end
    res.cnt = k;
    if (k != 2'd0) begin
      res.item[k - 2'd1].run_last  = 1'b1;
      res.item[k - 2'd1].frame_end = last_row && last_col;
    end
  end

endmodule

// ===== hw/rtl/vhps_res_fifo.sv =====
// Result queue: takes up to three results per cycle, hands out one per transaction.
// Register-based ring with a fill count for input flow control.
// Depends on vhps_pkg.
`timescale 1ns / 1ps

module vhps_res_fifo (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  vhps_pkg::res_bundle_t                   push,
  input  logic                                    pop,
  output vhps_pkg::res_t                          head,
  output logic                                    not_empty,
  output logic [$clog2(vhps_pkg::FIFO_DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(vhps_pkg::FIFO_DEPTH);
  localparam int NW = $clog2(vhps_pkg::FIFO_DEPTH + 1);

  vhps_pkg::res_t mem [vhps_pkg::FIFO_DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]  count_r, count_nxt;
  logic           do_pop;

  assign do_pop     = pop && (count_r != '0);
  assign wr_ptr_nxt = wr_ptr_r + PW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + PW'(do_pop);
  assign count_nxt  = count_r + NW'(push.cnt) - NW'(do_pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < vhps_pkg::MAX_RES; i++) begin
      if (i < int'(push.cnt)) begin
        mem[wr_ptr_r + PW'(i)] <= push.item[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head      = mem[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign count     = count_r;

endmodule

// ===== hw/rtl/vertical_half_pixel_shift_top.sv =====
// Vertical half-pixel shift of an 8-bit raster stream. One source pixel is taken per
// clock while in_tready is high; the pixel reads its column of the line memory (three
// previous rows, 24 bits wide, one read and one write per cycle, no clearing pass) and
// its filter results go into the result queue, whose head drives the output. Rows
// above the last give at most one result per pixel, so the block sustains one pixel per
// clock while results are taken every clock. Pixels of the last row give one to three
// results; those drain one per clock while out_tready is high through an eight-entry
// result queue, and in_tready drops while the queue cannot hold the results of the pixel
// in flight plus the next one. A write to any used register index restarts the frame.
// Depends on vhps_pkg, vhps_line_buf, vhps_kernel, vhps_res_fifo.
`timescale 1ns / 1ps

module vertical_half_pixel_shift_top #(
  parameter int MAX_WIDTH  = vhps_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = vhps_pkg::MAX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [7:0]                   in_tdata,   // [7:0] in_pixel
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [31:0]                  out_tdata,  // [7:0] out_pixel, [17:8] out_row,
                                                   // [27:18] out_col, [31:28] zero
  output logic                         out_tlast,  // run_last
  output logic                         out_tuser,  // frame_end
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [vhps_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [vhps_pkg::CFG_W-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int NW = $clog2(vhps_pkg::FIFO_DEPTH + 1);
  localparam int PW = vhps_pkg::PIX_W;

  logic [vhps_pkg::CFG_W-1:0] frame_width_r, frame_width_nxt;
  logic [vhps_pkg::CFG_W-1:0] frame_height_r, frame_height_nxt;
  logic                       shift_up_r, shift_up_nxt;
  logic [CW:0]                eff_w;
  logic [RW:0]                eff_h;
  logic [RW-1:0]              hm1;
  logic [CW-1:0]              wm1;

  logic [CW-1:0] col_cnt_r, col_cnt_nxt;
  logic [RW-1:0] row_cnt_r, row_cnt_nxt;
  logic          cfg_hit;
  logic          in_accept;
  logic          last_row;
  logic          last_col;

  logic          s1_valid_r;
  logic [PW-1:0] s1_pix_r;
  logic [CW-1:0] s1_col_r;
  logic [RW-1:0] s1_row_r;
  logic          s1_last_row_r;
  logic          s1_last_col_r;

  logic [3*PW-1:0]       line_rd;
  logic [3*PW-1:0]       line_wr;
  vhps_pkg::res_bundle_t kern_res;
  vhps_pkg::res_bundle_t push;
  vhps_pkg::res_t        head;
  logic                  q_not_empty;
  logic [NW-1:0]         q_count;

  // register file
  assign cfg_ready = 1'b1;
  assign cfg_hit   = cfg_valid && ((cfg_index == vhps_pkg::REG_FRAME_WIDTH) ||
                                   (cfg_index == vhps_pkg::REG_FRAME_HEIGHT) ||
                                   (cfg_index == vhps_pkg::REG_SHIFT_UP));

  always_comb begin
    frame_width_nxt  = frame_width_r;
    frame_height_nxt = frame_height_r;
    shift_up_nxt     = shift_up_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        vhps_pkg::REG_FRAME_WIDTH:  frame_width_nxt  = cfg_data;
        vhps_pkg::REG_FRAME_HEIGHT: frame_height_nxt = cfg_data;
        vhps_pkg::REG_SHIFT_UP:     shift_up_nxt     = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= vhps_pkg::FRAME_WIDTH_RST;
      frame_height_r <= vhps_pkg::FRAME_HEIGHT_RST;
      shift_up_r     <= 1'b0;
    end else begin
      frame_width_r  <= frame_width_nxt;
      frame_height_r <= frame_height_nxt;
      shift_up_r     <= shift_up_nxt;
    end
  end

  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = (CW + 1)'(1);
    end else if (int'(frame_width_r) > MAX_WIDTH) begin
      eff_w = (CW + 1)'(MAX_WIDTH);
    end else begin
      eff_w = (CW + 1)'(frame_width_r);
    end
    if (int'(frame_height_r) < 3) begin
      eff_h = (RW + 1)'(3);
    end else if (int'(frame_height_r) > MAX_HEIGHT) begin
      eff_h = (RW + 1)'(MAX_HEIGHT);
    end else begin
      eff_h = (RW + 1)'(frame_height_r);
    end
  end

  assign wm1 = CW'(eff_w - (CW + 1)'(1));
  assign hm1 = RW'(eff_h - (RW + 1)'(1));

  // position counters
  assign in_tready = s1_valid_r ? (q_count <= NW'(vhps_pkg::FIFO_DEPTH - 2 * vhps_pkg::MAX_RES))
                                : (q_count <= NW'(vhps_pkg::FIFO_DEPTH - vhps_pkg::MAX_RES));
  assign in_accept = in_tvalid && in_tready;
  assign last_col  = (col_cnt_r == wm1);
  assign last_row  = (row_cnt_r == hm1);

  always_comb begin
    col_cnt_nxt = col_cnt_r;
    row_cnt_nxt = row_cnt_r;
    priority if (cfg_hit) begin
      col_cnt_nxt = '0;
      row_cnt_nxt = '0;
    end else if (in_accept) begin
      if (last_col) begin
        col_cnt_nxt = '0;
        row_cnt_nxt = last_row ? '0 : row_cnt_r + RW'(1);
      end else begin
        col_cnt_nxt = col_cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r  <= '0;
      row_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      col_cnt_r  <= col_cnt_nxt;
      row_cnt_r  <= row_cnt_nxt;
      s1_valid_r <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix_r      <= in_tdata;
      s1_col_r      <= col_cnt_r;
      s1_row_r      <= row_cnt_r;
      s1_last_row_r <= last_row;
      s1_last_col_r <= last_col;
    end
  end

  // line memory: {m3, m2, m1}, shift down one row on write-back
  assign line_wr = {line_rd[2*PW-1:PW], line_rd[PW-1:0], s1_pix_r};

  vhps_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (col_cnt_r),
    .wr_en   (s1_valid_r),
    .wr_addr (s1_col_r),
    .wr_data (line_wr),
    .rd_data (line_rd)
  );

  vhps_kernel #(
    .RW (RW),
    .CW (CW)
  ) u_kernel (
    .cur      (s1_pix_r),
    .m1       (line_rd[PW-1:0]),
    .m2       (line_rd[2*PW-1:PW]),
    .m3       (line_rd[3*PW-1:2*PW]),
    .row      (s1_row_r),
    .col      (s1_col_r),
    .hm1      (hm1),
    .up       (shift_up_r),
    .last_row (s1_last_row_r),
    .last_col (s1_last_col_r),
    .res      (kern_res)
  );

  always_comb begin
    push = kern_res;
    if (!s1_valid_r) begin
      push.cnt = '0;
    end
  end

  vhps_res_fifo u_res_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (out_tready),
    .head      (head),
    .not_empty (q_not_empty),
    .count     (q_count)
  );

  assign out_tvalid = q_not_empty;
  assign out_tdata  = {4'd0, head.col, head.row, head.pixel};
  assign out_tlast  = head.run_last;
  assign out_tuser  = head.frame_end;

  a_frame_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("frame end result without run end");

  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (col_cnt_r == '0) && (row_cnt_r == '0))
    else $error("frame position not restarted by register write");

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, col_cnt_r} < eff_w)
    else $error("column counter beyond frame width");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, row_cnt_r} < eff_h)
    else $error("row counter beyond frame height");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for vertical_half_pixel_shift_top: streams raster frames through
// the pixel port under random stalls and compares every shifted pixel with a local model.
// Depends on vhps_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;

  localparam logic [vhps_pkg::CIDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic out_tlast;
  logic out_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [vhps_pkg::CIDX_W-1:0] cfg_index = '0;
  logic [vhps_pkg::CFG_W-1:0] cfg_data = '0;

  vertical_half_pixel_shift_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the block's registers, line stores and raster position
  logic [vhps_pkg::CFG_W-1:0] width_reg = vhps_pkg::FRAME_WIDTH_RST;
  logic [vhps_pkg::CFG_W-1:0] height_reg = vhps_pkg::FRAME_HEIGHT_RST;
  logic up_reg = 1'b0;
  logic [7:0] line_m1 [vhps_pkg::MAX_WIDTH_DEF];
  logic [7:0] line_m2 [vhps_pkg::MAX_WIDTH_DEF];
  logic [7:0] line_m3 [vhps_pkg::MAX_WIDTH_DEF];
  int row_pos = 0;
  int col_pos = 0;

  logic [7:0] source_q [$];
  vhps_pkg::res_t shifted_q [$];

  bit steady = 1'b0;
  int send_gap = 0;
  int hold_left = 0;
  int fail_count = 0;
  int checked_count = 0;
  int frame_count = 0;
  int sent_count = 0;
  int cfg_count = 0;

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > vhps_pkg::MAX_WIDTH_DEF) return vhps_pkg::MAX_WIDTH_DEF;
    return int'(width_reg);
  endfunction

  function automatic int eff_height();
    if (height_reg < 3) return 3;
    if (height_reg > vhps_pkg::MAX_HEIGHT_DEF) return vhps_pkg::MAX_HEIGHT_DEF;
    return int'(height_reg);
  endfunction

  function automatic vhps_pkg::res_t make_res(int pix, int row, int col);
    vhps_pkg::res_t r;
    r.pixel = vhps_pkg::PIX_W'(pix);
    r.row = vhps_pkg::ROW_W'(row);
    r.col = vhps_pkg::COL_W'(col);
    r.run_last = 1'b0;
    r.frame_end = 1'b0;
    return r;
  endfunction

  function automatic void apply_reg(logic [vhps_pkg::CIDX_W-1:0] idx,
                                    logic [vhps_pkg::CFG_W-1:0] val);
    case (idx)
      vhps_pkg::REG_FRAME_WIDTH: width_reg = val;
      vhps_pkg::REG_FRAME_HEIGHT: height_reg = val;
      vhps_pkg::REG_SHIFT_UP: up_reg = val[0];
      default: return;
    endcase
    row_pos = 0;
    col_pos = 0;
  endfunction

  function automatic void shift_source_pixel(logic [7:0] cur);
    vhps_pkg::res_t batch [$];
    int w, h, c, p, a1, a2, a3, sum;
    bit last_row, last_col;
    w = eff_width();
    h = eff_height();
    c = col_pos % vhps_pkg::MAX_WIDTH_DEF;
    p = int'(cur);
    a1 = int'(line_m1[c]);
    a2 = int'(line_m2[c]);
    a3 = int'(line_m3[c]);
    last_row = (row_pos + 1 >= h);
    last_col = (col_pos + 1 >= w);
    if (row_pos == 0) begin
      if (up_reg) batch.push_back(make_res(p, 0, c));
    end else if (row_pos == 1) begin
      batch.push_back(make_res((a1 + p) >> 1, up_reg ? 1 : 0, c));
    end
    if (row_pos >= 3) begin
      sum = (5 * (a2 + a1) - a3 - p) >>> 3;
      if (sum < 0) sum = 0;
      if (sum > 255) sum = 255;
      batch.push_back(make_res(sum, up_reg ? row_pos - 1 : row_pos - 2, c));
    end
    if (last_row) begin
      batch.push_back(make_res((a1 + p) >> 1, up_reg ? h - 1 : h - 2, c));
      if (!up_reg) batch.push_back(make_res(p, h - 1, c));
    end
    if (batch.size() != 0) begin
      batch[$].run_last = 1'b1;
      batch[$].frame_end = last_row && last_col;
    end
    foreach (batch[k]) shifted_q.push_back(batch[k]);
    line_m3[c] = line_m2[c];
    line_m2[c] = line_m1[c];
    line_m1[c] = cur;
    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  function automatic int next_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Pixel driver: present the next queued pixel, predict on each accepted transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) shift_source_pixel(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (source_q.size() != 0) begin
          in_tdata <= source_q.pop_front();
          in_tvalid <= 1'b1;
          send_gap = next_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each accepted transaction with the oldest prediction
  always @(posedge clk) begin : result_monitor
    vhps_pkg::res_t got;
    vhps_pkg::res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.pixel = out_tdata[7:0];
        got.row = out_tdata[17:8];
        got.col = out_tdata[27:18];
        got.run_last = out_tlast;
        got.frame_end = out_tuser;
        if (got.frame_end) frame_count++;
        if (shifted_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: unexpected result pix %0d row %0d col %0d last %0b end %0b",
                     $realtime, got.pixel, got.row, got.col, got.run_last, got.frame_end);
        end else begin
          want = shifted_q.pop_front();
          checked_count++;
          if (got.pixel !== want.pixel || got.row !== want.row || got.col !== want.col ||
              got.run_last !== want.run_last || got.frame_end !== want.frame_end) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"%0t: mismatch want pix %0d row %0d col %0d last %0b end %0b, ",
                        "got pix %0d row %0d col %0d last %0b end %0b"},
                       $realtime, want.pixel, want.row, want.col, want.run_last,
                       want.frame_end, got.pixel, got.row, got.col, got.run_last,
                       got.frame_end);
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        hold_left = next_gap();
      end
    end
  end

  task automatic push_pixels(int n, bit harsh);
    repeat (n) begin
      if (harsh) source_q.push_back($urandom_range(0, 1) ? 8'd255 : 8'd0);
      else source_q.push_back(8'($urandom_range(0, 255)));
      sent_count++;
    end
  endtask

  // Hold until every pixel is accepted and every result has arrived, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk);
    while (source_q.size() != 0 || in_tvalid || shifted_q.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [vhps_pkg::CIDX_W-1:0] idx, logic [vhps_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
    cfg_count++;
    @(negedge clk);
  endtask

  initial begin : stimulus
    int frame_px, cut, kind, nwr, random_sent;
    logic [vhps_pkg::CIDX_W-1:0] idx;
    logic [vhps_pkg::CFG_W-1:0] val;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset sizes, shift down: the top row alone yields nothing
    push_pixels(5, 1'b0);
    wait_drained();

    // Inner taps driven to both clamp limits, top row kept
    cfg_write(vhps_pkg::REG_FRAME_WIDTH, 11'd2);
    cfg_write(vhps_pkg::REG_FRAME_HEIGHT, 11'd4);
    cfg_write(vhps_pkg::REG_SHIFT_UP, 11'd1);
    source_q = {8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0};
    sent_count += 8;
    wait_drained();

    // Minimum height, bottom row kept
    cfg_write(vhps_pkg::REG_SHIFT_UP, 11'd0);
    cfg_write(vhps_pkg::REG_FRAME_WIDTH, 11'd4);
    cfg_write(vhps_pkg::REG_FRAME_HEIGHT, 11'd3);
    push_pixels(12, 1'b1);
    wait_drained();

    // Out-of-range sizes: width above the maximum with height below three, then the reverse
    cfg_write(vhps_pkg::REG_FRAME_WIDTH, 11'd2047);
    cfg_write(vhps_pkg::REG_FRAME_HEIGHT, 11'd0);
    cfg_write(vhps_pkg::REG_SHIFT_UP, 11'd1);
    push_pixels(24, 1'b0);
    wait_drained();
    cfg_write(vhps_pkg::REG_FRAME_WIDTH, 11'd0);
    cfg_write(vhps_pkg::REG_FRAME_HEIGHT, 11'd2047);
    push_pixels(24, 1'b0);
    wait_drained();

    random_sent = 0;
    while (random_sent < 200) begin
      steady = ($urandom_range(0, 3) == 0);
      nwr = $urandom_range(1, 3);
      repeat (nwr) begin
        idx = vhps_pkg::CIDX_W'($urandom_range(0, 2));
        case (idx)
          vhps_pkg::REG_FRAME_WIDTH:
            val = ($urandom_range(0, 9) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
          vhps_pkg::REG_FRAME_HEIGHT:
            val = ($urandom_range(0, 5) == 0) ? 11'($urandom_range(0, 2))
                                                : 11'($urandom_range(3, 8));
          vhps_pkg::REG_SHIFT_UP: val = 11'($urandom_range(0, 2047));
          default: val = '0;
        endcase
        cfg_write(idx, val);
      end
      frame_px = eff_width() * eff_height();
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        cut = frame_px * $urandom_range(1, 2);
        push_pixels(cut, $urandom_range(0, 4) == 0);
      end else if (kind < 9) begin
        // broken frame, abandoned by the next phase's register writes
        cut = $urandom_range(1, frame_px - 1);
        push_pixels(cut, 1'b0);
      end else begin
        // an unused register index must not restart the frame
        cut = $urandom_range(1, frame_px - 1);
        push_pixels(cut, 1'b0);
        wait_drained();
        cfg_write(REG_UNUSED, 11'($urandom_range(0, 2047)));
        push_pixels(frame_px - cut, 1'b0);
        cut = frame_px;
      end
      random_sent += cut;
      wait_drained();
    end

    steady = 1'b0;
    wait_drained();
    $display("Sent %0d source pixels across %0d register writes.", sent_count, cfg_count);
    $display("Checked %0d shifted pixels, %0d frame ends, %0d failures.",
             checked_count, frame_count, fail_count + shifted_q.size());
    if (fail_count == 0 && shifted_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #(50_000_000);
    $display("tb failed");
    $finish;
  end

endmodule
